/* design/dgo_pkg.sv */
// ----------------------------------------------------------------------------
// dgo_pkg
// Shared widths, register indexes, configuration bundle and digit font for
// the digit glyph overlay.
// ----------------------------------------------------------------------------
package dgo_pkg;

  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 16;
  localparam int NUM_W      = 17;
  localparam int ANCHOR_W   = 13;
  localparam int DIM_W      = 13;
  localparam int LABEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIGIT_W    = 4;

  localparam int GLYPH_W = 4;
  localparam int GLYPH_H = 6;

  localparam int MAX_DIGITS_DEF = 5;
  localparam int MAX_DIM_DEF    = 4096;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUMBER   = 3'd0,
    REG_ANCHOR_X = 3'd1,
    REG_ANCHOR_Y = 3'd2,
    REG_LABEL    = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ANCHOR_W-1:0] anchor_x;
    logic signed [ANCHOR_W-1:0] anchor_y;
    logic [LABEL_W-1:0]         stamp_label;
    logic [DIM_W-1:0]           image_width;
    logic [DIM_W-1:0]           image_height;
  } cfg_t;

  // Font rows; bit 3 is the left column of the cell.
  localparam logic [GLYPH_W-1:0] GLYPH_ROWS [10][GLYPH_H] = '{
    '{4'h0, 4'h7, 4'h5, 4'h5, 4'h5, 4'h7},
    '{4'h0, 4'h6, 4'h2, 4'h2, 4'h2, 4'h7},
    '{4'h0, 4'h7, 4'h1, 4'h7, 4'h4, 4'h7},
    '{4'h0, 4'h7, 4'h1, 4'h7, 4'h1, 4'h7},
    '{4'h0, 4'h5, 4'h5, 4'h7, 4'h1, 4'h1},
    '{4'h0, 4'h7, 4'h4, 4'h7, 4'h1, 4'h7},
    '{4'h0, 4'h7, 4'h4, 4'h7, 4'h5, 4'h7},
    '{4'h0, 4'h7, 4'h1, 4'h2, 4'h4, 4'h4},
    '{4'h0, 4'h7, 4'h5, 4'h7, 4'h5, 4'h7},
    '{4'h0, 4'h7, 4'h5, 4'h7, 4'h1, 4'h7}
  };

  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [DIGIT_W-1:0] digit,
                                                   input logic [2:0] row);
    logic [GLYPH_W-1:0] bits;
    bits = '0;
    if ((digit < 4'd10) && (row < 3'(GLYPH_H))) begin
      bits = GLYPH_ROWS[digit][row];
    end
    return bits;
  endfunction

endpackage

/* design/dgo_pix_in_if.sv */
// ----------------------------------------------------------------------------
// dgo_pix_in_if
// Incoming pixel channel: coordinates and original label value.
// ----------------------------------------------------------------------------
interface dgo_pix_in_if
  import dgo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] pixel_col;
  logic [ROW_W-1:0] pixel_row;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_col, output pixel_row, output pixel_in,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input pixel_in,
                  output ready);
endinterface

/* design/dgo_pix_out_if.sv */
// ----------------------------------------------------------------------------
// dgo_pix_out_if
// Outgoing pixel channel: resulting value and the covered flag.
// ----------------------------------------------------------------------------
interface dgo_pix_out_if
  import dgo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             covered;

  modport source (output valid, output pixel_out, output covered, input ready);
  modport sink   (input valid, input pixel_out, input covered, output ready);
endinterface

/* design/dgo_cfg_if.sv */
// ----------------------------------------------------------------------------
// dgo_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dgo_cfg_if
  import dgo_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

/* design/dgo_bcd_conv.sv */
// ----------------------------------------------------------------------------
// dgo_bcd_conv
// Shift-and-add-three binary to decimal converter, one bit per cycle, with
// saturation of the number to the largest value that fits in the digits.
// ----------------------------------------------------------------------------
module dgo_bcd_conv
  import dgo_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [NUM_W-1:0]                  value_i,
  output logic                              busy_o,
  output logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint unsigned LIMIT = pow10(MAX_DIGITS) - 1;

  logic [NUM_W-1:0]                   bin_q, bin_d;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] bcd_q, bcd_d, bcd_adj;
  logic [MAX_DIGITS*DIGIT_W-1:0]      adj_flat;
  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic                               busy_q, busy_d;
  logic [NUM_W-1:0]                   sat_value;
  logic                               digits_ok;

  assign sat_value = (64'(value_i) > LIMIT) ? NUM_W'(LIMIT) : value_i;

  always_comb begin
    for (int j = 0; j < MAX_DIGITS; j++) begin
      bcd_adj[j] = (bcd_q[j] >= 4'd5) ? (bcd_q[j] + 4'd3) : bcd_q[j];
    end
  end

  // The adjusted digits as one flat vector, so that the shift moves bits.
  assign adj_flat = bcd_adj;

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i) begin
      bin_d  = sat_value;
      bcd_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d  = bin_q << 1;
      bcd_d  = {adj_flat[MAX_DIGITS*DIGIT_W-2:0], bin_q[NUM_W-1]};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q  <= '0;
      bcd_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      bin_q  <= bin_d;
      bcd_q  <= bcd_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o   = busy_q;
  assign digits_o = bcd_q;

  always_comb begin
    digits_ok = 1'b1;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (bcd_q[j] > 4'd9) digits_ok = 1'b0;
    end
  end

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> busy_q)
    else $error("conversion did not start after a number write");

  a_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cnt_q == CNT_W'(1)) && !load_i) |=> !busy_q)
    else $error("conversion did not finish after the last shift");

  a_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_ok)
    else $error("a decimal digit holds a value above nine");

endmodule

/* design/dgo_cfg.sv */
// ----------------------------------------------------------------------------
// dgo_cfg
// Configuration registers and the decimal form of the number to draw.
// ----------------------------------------------------------------------------
module dgo_cfg
  import dgo_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dgo_cfg_if.sink                            cfg_in,
  output cfg_t                               cfg_o,
  output logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_o,
  output logic [MAX_DIGITS-1:0]              digit_en_o,
  output logic                               busy_o
);

  cfg_t cfg_q, cfg_d;
  logic write;
  logic load_number;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;

  assign cfg_in.ready = 1'b1;
  assign write        = cfg_in.valid;

  always_comb begin
    cfg_d       = cfg_q;
    load_number = 1'b0;
    if (write) begin
      unique case (cfg_reg_e'(cfg_in.reg_idx))
        REG_NUMBER:   load_number        = 1'b1;
        REG_ANCHOR_X: cfg_d.anchor_x     = cfg_in.wdata[ANCHOR_W-1:0];
        REG_ANCHOR_Y: cfg_d.anchor_y     = cfg_in.wdata[ANCHOR_W-1:0];
        REG_LABEL:    cfg_d.stamp_label  = cfg_in.wdata[LABEL_W-1:0];
        REG_WIDTH:    cfg_d.image_width  = cfg_in.wdata[DIM_W-1:0];
        REG_HEIGHT:   cfg_d.image_height = cfg_in.wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.anchor_x     <= '0;
      cfg_q.anchor_y     <= '0;
      cfg_q.stamp_label  <= '0;
      cfg_q.image_width  <= DIM_RESET;
      cfg_q.image_height <= DIM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dgo_bcd_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_number),
    .value_i  (cfg_in.wdata[NUM_W-1:0]),
    .busy_o   (busy_o),
    .digits_o (digits)
  );

  // A digit is drawn when it or any more significant digit is non-zero; the
  // least significant digit is always drawn.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = MAX_DIGITS - 1; j >= 0; j--) begin
      seen          = seen | (digits[j] != '0);
      digit_en_o[j] = seen | (j == 0);
    end
  end

  assign cfg_o    = cfg_q;
  assign digits_o = digits;

endmodule

/* design/dgo_pipe.sv */
// ----------------------------------------------------------------------------
// dgo_pipe
// Three-stage pixel pipeline: cell offsets, digit selection, font lookup.
// ----------------------------------------------------------------------------
module dgo_pipe
  import dgo_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cfg_t                               cfg_i,
  input  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_i,
  input  logic [MAX_DIGITS-1:0]              digit_en_i,
  input  logic                               busy_i,
  dgo_pix_in_if.sink                         pix_in,
  dgo_pix_out_if.source                      pix_out
);

  localparam int DW   = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W;
  localparam int JW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int OFF_W = ANCHOR_W + 2;
  localparam int DY_W  = ANCHOR_W + 1;

  logic rdy1, rdy2, rdy3, accept;

  // Stage 1 registers.
  logic                    v1_q, v1_d;
  logic                    img1_q, img1_d;
  logic signed [OFF_W-1:0] off1_q, off1_d;
  logic signed [DY_W-1:0]  dy1_q, dy1_d;
  logic [PIX_W-1:0]        pix1_q;

  // Stage 2 registers.
  logic                    v2_q;
  logic                    pre2_q, pre2_d;
  logic [DIGIT_W-1:0]      dig2_q, dig2_d;
  logic [2:0]              row2_q;
  logic [1:0]              bsel2_q;
  logic [PIX_W-1:0]        pix2_q;

  // Output registers.
  logic                    v3_q;
  logic                    hit3_d;
  logic [GLYPH_W-1:0]      bits3;
  logic [PIX_W-1:0]        pix3_q, pix3_d;
  logic                    cov3_q;

  logic [DW-1:0]           w_ext, h_ext, w_lim, h_lim;
  logic [COL_W-1:0]        cell_idx;
  logic                    in_range, row_ok;
  logic [JW-1:0]           sel;

  assign rdy3         = !v3_q || pix_out.ready;
  assign rdy2         = !v2_q || rdy3;
  assign rdy1         = !v1_q || rdy2;
  assign pix_in.ready = rdy1 && !busy_i;
  assign accept       = pix_in.valid && pix_in.ready;

  // Stage 1: image bounds and offsets. off is the distance from the pixel to
  // the right column of the least significant cell; dy is the row in the cell.
  assign w_ext  = DW'(cfg_i.image_width);
  assign h_ext  = DW'(cfg_i.image_height);
  assign w_lim  = (w_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : w_ext;
  assign h_lim  = (h_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : h_ext;
  assign v1_d   = accept;
  assign img1_d = (DW'(pix_in.pixel_col) < w_lim) && (DW'(pix_in.pixel_row) < h_lim);
  assign off1_d = OFF_W'(cfg_i.anchor_x) + OFF_W'(3)
                  - $signed({{(OFF_W-COL_W){1'b0}}, pix_in.pixel_col});
  assign dy1_d  = $signed({{(DY_W-ROW_W){1'b0}}, pix_in.pixel_row})
                  - DY_W'(cfg_i.anchor_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      img1_q <= img1_d;
      off1_q <= off1_d;
      dy1_q  <= dy1_d;
      pix1_q <= pix_in.pixel_in;
    end
  end

  // Stage 2: which digit cell the pixel falls in, and whether it is drawn.
  assign cell_idx = off1_q[COL_W+1:2];
  assign in_range = !off1_q[OFF_W-1] && (cell_idx < COL_W'(MAX_DIGITS));
  assign row_ok   = !dy1_q[DY_W-1] && (dy1_q[DY_W-2:0] < (DY_W-1)'(GLYPH_H));
  assign sel      = in_range ? cell_idx[JW-1:0] : '0;
  assign pre2_d   = img1_q && row_ok && in_range && digit_en_i[sel];
  assign dig2_d   = digits_i[sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pre2_q  <= pre2_d;
      dig2_q  <= dig2_d;
      row2_q  <= dy1_q[2:0];
      bsel2_q <= off1_q[1:0];
      pix2_q  <= pix1_q;
    end
  end

  // Stage 3: font lookup and the output value.
  assign bits3  = glyph_row(dig2_q, row2_q);
  assign hit3_d = pre2_q && bits3[bsel2_q];
  assign pix3_d = hit3_d ? cfg_i.stamp_label : pix2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pix3_q <= pix3_d;
      cov3_q <= hit3_d;
    end
  end

  assign pix_out.valid     = v3_q;
  assign pix_out.pixel_out = pix3_q;
  assign pix_out.covered   = cov3_q;

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted pixel did not reach the first stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("pixel lost between the second stage and the output");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !pix_out.ready) |-> !pix_in.ready)
    else $error("input taken while every stage is held");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |-> !pix_in.ready)
    else $error("input taken while the number conversion runs");

endmodule

/* design/digit_glyph_overlay_core.sv */
// ----------------------------------------------------------------------------
// digit_glyph_overlay_core
// Stamps a decimal number in a 4x6 font onto a stream of label pixels.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock unless an output stall or a number
// conversion holds its input, and returns each result in order through a
// three-stage pipeline (cell offsets, digit selection, font lookup) whose
// last stage is the output register; a stall on the output holds every stage
// without loss. Configuration writes are taken in every cycle. Writing
// number_value starts a binary to decimal conversion of the NUM_W (17) bits,
// one bit per cycle in the shift-and-add converter, during which no pixel is
// accepted; other registers act once registered, in the stage reading them.
module digit_glyph_overlay_core
  import dgo_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dgo_cfg_if.sink       cfg_in,
  dgo_pix_in_if.sink    pix_in,
  dgo_pix_out_if.source pix_out
);

  cfg_t                               cfg;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [MAX_DIGITS-1:0]              digit_en;
  logic                               busy;

  dgo_cfg #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_in     (cfg_in),
    .cfg_o      (cfg),
    .digits_o   (digits),
    .digit_en_o (digit_en),
    .busy_o     (busy)
  );

  dgo_pipe #(
    .MAX_DIGITS (MAX_DIGITS),
    .MAX_DIM    (MAX_DIM)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .digits_i   (digits),
    .digit_en_i (digit_en),
    .busy_i     (busy),
    .pix_in     (pix_in),
    .pix_out    (pix_out)
  );

endmodule

/* verif/tb_digit_glyph_overlay_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_digit_glyph_overlay_core
// Self-checking bench for the digit glyph overlay. Pixels are streamed through
// the core under a series of overlay settings, and each returned pixel is
// compared with a local prediction of the font stamp, in transfer order.
// ----------------------------------------------------------------------------
module tb_digit_glyph_overlay_core;
  import dgo_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_PIXELS = 140;
  localparam int QUIET_PHASES = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             covered;
  } overlay_result_t;

  class overlay_scoreboard;
    logic [NUM_W-1:0]           number_value;
    logic signed [ANCHOR_W-1:0] anchor_x;
    logic signed [ANCHOR_W-1:0] anchor_y;
    logic [LABEL_W-1:0]         stamp_label;
    logic [DIM_W-1:0]           image_width;
    logic [DIM_W-1:0]           image_height;
    overlay_result_t            stamped_pixels_q[$];
    int errors;
    int checked;
    int stamped;
    int writes;

    function new();
      number_value = '0;
      anchor_x     = '0;
      anchor_y     = '0;
      stamp_label  = '0;
      image_width  = DIM_RESET;
      image_height = DIM_RESET;
      errors  = 0;
      checked = 0;
      stamped = 0;
      writes  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      case (idx)
        REG_NUMBER:   number_value = data[NUM_W-1:0];
        REG_ANCHOR_X: anchor_x     = data[ANCHOR_W-1:0];
        REG_ANCHOR_Y: anchor_y     = data[ANCHOR_W-1:0];
        REG_LABEL:    stamp_label  = data[LABEL_W-1:0];
        REG_WIDTH:    image_width  = data[DIM_W-1:0];
        REG_HEIGHT:   image_height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Six font rows per digit packed top row first; the nibble's MSB is the
    // left column of the cell.
    function bit font_bit(int digit, int dy, int dx);
      logic [23:0] rows;
      case (digit)
        0: rows = 24'h075557;
        1: rows = 24'h062227;
        2: rows = 24'h071747;
        3: rows = 24'h071717;
        4: rows = 24'h055711;
        5: rows = 24'h074717;
        6: rows = 24'h074757;
        7: rows = 24'h071244;
        8: rows = 24'h075757;
        default: rows = 24'h075717;
      endcase
      return rows[23 - 4 * dy - dx];
    endfunction

    function bit glyph_covers(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
      int w;
      int h;
      int dy;
      int dx;
      int left;
      int unsigned k;
      w = (image_width > 13'd4096) ? 4096 : int'(image_width);
      h = (image_height > 13'd4096) ? 4096 : int'(image_height);
      if (int'(col) >= w || int'(row) >= h) return 1'b0;
      dy = int'(row) - int'(anchor_y);
      if (dy < 0 || dy >= GLYPH_H) return 1'b0;
      k = number_value;
      if (k > 99999) k = 99999;
      left = int'(anchor_x);
      // Least significant digit first, each further digit one cell to the left.
      do begin
        dx = int'(col) - left;
        if (dx >= 0 && dx < GLYPH_W && font_bit(k % 10, dy, dx)) return 1'b1;
        k = k / 10;
        left -= GLYPH_W;
      end while (k > 0);
      return 1'b0;
    endfunction

    function void note_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                             logic [PIX_W-1:0] pix);
      overlay_result_t res;
      res.covered   = glyph_covers(col, row);
      res.pixel_out = res.covered ? stamp_label : pix;
      stamped_pixels_q.push_back(res);
    endfunction

    function void check_result(logic [PIX_W-1:0] pixel_out, logic covered);
      overlay_result_t exp_res;
      if (stamped_pixels_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel out=%h covered=%0b", $time, pixel_out, covered);
        return;
      end
      exp_res = stamped_pixels_q.pop_front();
      checked++;
      if (exp_res.covered) stamped++;
      if (pixel_out !== exp_res.pixel_out) begin
        errors++;
        $display("%0t: pixel_out mismatch: expected %h, actual %h", $time,
                 exp_res.pixel_out, pixel_out);
      end
      if (covered !== exp_res.covered) begin
        errors++;
        $display("%0t: covered mismatch: expected %0b, actual %0b", $time,
                 exp_res.covered, covered);
      end
    endfunction

    function int pending();
      return stamped_pixels_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on = 1'b0;
  bit   hold_req = 1'b0;
  int   cycle_count = 0;
  int   settings_count = 0;
  overlay_scoreboard sb;

  dgo_cfg_if     cfg_bus ();
  dgo_pix_in_if  pix_in_bus ();
  dgo_pix_out_if pix_out_bus ();

  digit_glyph_overlay_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_in  (cfg_bus),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.reg_idx, cfg_bus.wdata);
      if (pix_in_bus.valid && pix_in_bus.ready)
        sb.note_pixel(pix_in_bus.pixel_col, pix_in_bus.pixel_row, pix_in_bus.pixel_in);
      if (pix_out_bus.valid && pix_out_bus.ready)
        sb.check_result(pix_out_bus.pixel_out, pix_out_bus.covered);
    end
  end

  // Output back-pressure: short random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    pix_out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pix_out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        pix_out_bus.ready <= 1'b0;
      end else begin
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles.", cycle_count);
    $display("status: fail");
    $finish;
  end

  task automatic send_pixel(int col, int row, int pix);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in_bus.valid     <= 1'b1;
    pix_in_bus.pixel_col <= COL_W'(col);
    pix_in_bus.pixel_row <= ROW_W'(row);
    pix_in_bus.pixel_in  <= PIX_W'(pix);
    do @(posedge clk_i); while (!pix_in_bus.ready);
  endtask

  // Stops the pixel stream and waits until every sent pixel has come back.
  task automatic drain_stream();
    @(negedge clk_i);
    pix_in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.reg_idx <= idx;
    cfg_bus.wdata   <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  // Upper write-data bits above each register's width, the number register's apart, carry junk on purpose.
  task automatic program_overlay(int num, int ax, int ay, int label, int w, int h);
    drain_stream();
    write_register(REG_NUMBER, CFG_DATA_W'(num));
    write_register(REG_ANCHOR_X, {4'($urandom), 13'(ax)});
    write_register(REG_ANCHOR_Y, {4'($urandom), 13'(ay)});
    write_register(REG_LABEL, {1'($urandom), 16'(label)});
    write_register(REG_WIDTH, {4'($urandom), 13'(w)});
    write_register(REG_HEIGHT, {4'($urandom), 13'(h)});
    if ($urandom_range(0, 1) == 0) write_register(REG_SPARE_6, CFG_DATA_W'($urandom));
    else write_register(REG_SPARE_7, CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    settings_count++;
  endtask

  function automatic int pick_number();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 99999;
      2: return $urandom_range(100000, 131071);
      3: return $urandom_range(0, 9);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  function automatic int pick_anchor();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      2: return $urandom_range(0, 8191);
      default: return int'($urandom_range(0, 700)) - 20;
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 4096;
      3: return $urandom_range(4097, 8191);
      default: return $urandom_range(16, 700);
    endcase
  endfunction

  // Most pixels land on or around the digit cells; the rest probe the image
  // edges or fall anywhere.
  task automatic send_random_pixel();
    int col;
    int row;
    int w;
    int h;
    w = (sb.image_width > 13'd4096) ? 4096 : int'(sb.image_width);
    h = (sb.image_height > 13'd4096) ? 4096 : int'(sb.image_height);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        col = int'(sb.anchor_x) - 20 + int'($urandom_range(0, 24));
        row = int'(sb.anchor_y) - 1 + int'($urandom_range(0, 7));
      end
      6, 7: begin
        col = w - 2 + int'($urandom_range(0, 3));
        row = ($urandom_range(0, 1) == 0) ? h - 2 + int'($urandom_range(0, 3))
                                          : int'($urandom_range(0, 4095));
      end
      default: begin
        col = $urandom_range(0, 4095);
        row = $urandom_range(0, 4095);
      end
    endcase
    send_pixel(col, row, $urandom_range(0, 65535));
  endtask

  initial begin
    int p;
    int n;
    sb = new();
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_idx      = '0;
    cfg_bus.wdata        = '0;
    pix_in_bus.valid     = 1'b0;
    pix_in_bus.pixel_col = '0;
    pix_in_bus.pixel_row = '0;
    pix_in_bus.pixel_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: a single zero digit at the origin, full-size image.
    send_pixel(0, 0, 0);
    send_pixel(1, 1, 16'hFFFF);
    send_pixel(0, 1, 16'h5A5A);
    send_pixel(4095, 4095, 16'hFFFF);
    send_pixel(4095, 0, 16'h1234);
    send_pixel(0, 4095, 16'h8001);

    // Five digits inside a 640 x 480 image.
    program_overlay(12345, 20, 10, 16'hA5A5, 640, 480);
    send_pixel(21, 11, 16'h0F0F);
    send_pixel(17, 11, 16'h0F0F);
    send_pixel(5, 15, 16'h00FF);
    send_pixel(1, 15, 16'h00FF);
    send_pixel(23, 10, 16'hFFFF);
    send_pixel(24, 11, 16'h7777);
    send_pixel(640, 11, 16'h2222);
    send_pixel(639, 479, 16'h3333);
    send_pixel(21, 480, 16'h4444);

    // Over-long number saturates to all nines; cells hang off the top left.
    program_overlay(131071, -2, -3, 16'hFFFF, 8191, 4097);
    send_pixel(0, 0, 16'h0000);
    send_pixel(1, 2, 16'h0001);
    send_pixel(4095, 4095, 16'hFFFF);

    // Zero width lets every pixel through.
    program_overlay(99999, 0, 0, 16'h1234, 0, 4096);
    send_pixel(1, 1, 16'hCAFE);
    send_pixel(2, 3, 16'hBEEF);

    for (p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p < RAND_PHASES - QUIET_PHASES);
      case (p)
        0: program_overlay(99999, 4092, 4090, 16'hFFFF, 4096, 4096);
        1: program_overlay(0, -4096, -4096, 0, 1, 1);
        2: program_overlay(8, 0, 0, 16'h8000, 4096, 4096);
        default: program_overlay(pick_number(), pick_anchor(), pick_anchor(),
                                 $urandom_range(0, 65535), pick_dim(), pick_dim());
      endcase
      // One long output hold-off while pixels keep coming, so the core fills up.
      if (p == 3) hold_req = 1'b1;
      for (n = 0; n < PHASE_PIXELS; n++) send_random_pixel();
    end

    drain_stream();
    $display("Checked %0d pixels (%0d stamped) across %0d overlay settings.",
             sb.checked, sb.stamped, settings_count + 1);
    $display("Issued %0d register writes, spare indexes included, with one long output stall.",
             sb.writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* digit_glyph_overlay_core.f */
design/dgo_pkg.sv
design/dgo_pix_in_if.sv
design/dgo_pix_out_if.sv
design/dgo_cfg_if.sv
design/dgo_bcd_conv.sv
design/dgo_cfg.sv
design/dgo_pipe.sv
design/digit_glyph_overlay_core.sv
verif/tb_digit_glyph_overlay_core.sv
